// ----- design/clw_pkg.sv -----
// Shared types and constants for the character LCD text stream writer.
// Used by the controller, the datapath and the top level; no dependencies.
package clw_pkg;

    // Default DDRAM line length in characters.
    localparam int CLW_DDRAM_LINE_LEN = 40;

    // Field widths.
    localparam int CHAR_W      = 8;
    localparam int COL_W       = 6;
    localparam int ROW_W       = 2;
    localparam int LINES_W     = 3;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [LINES_W-1:0] LINE_COUNT_RESET   = 3'd2;
    localparam logic [COL_W-1:0]   COLUMN_COUNT_RESET = 6'd16;

    // Characters and bus codes.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CMD_SET_DDRAM = 8'h80;

    // DDRAM line start addresses.
    localparam logic [CHAR_W-1:0] ADDR_LINE0    = 8'h00;
    localparam logic [CHAR_W-1:0] ADDR_LINE1    = 8'h40;
    localparam logic [CHAR_W-1:0] ADDR_L2_C12   = 8'h0C;
    localparam logic [CHAR_W-1:0] ADDR_L3_C12   = 8'h4C;
    localparam logic [CHAR_W-1:0] ADDR_L2_C16   = 8'h10;
    localparam logic [CHAR_W-1:0] ADDR_L3_C16   = 8'h50;
    localparam logic [CHAR_W-1:0] ADDR_L2_C20   = 8'h14;
    localparam logic [CHAR_W-1:0] ADDR_L3_C20   = 8'h54;

    // Register select codes.
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_char;
        logic emit_char;
        logic emit_pad;
        logic emit_cmd;
    } clw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_newline;
        logic col_lt_len;
        logic col_lt_limit;
        logic pad_last;
        logic cmd_ok;
        logic out_free;
    } clw_status_t;

endpackage

// ----- design/clw_ctrl.sv -----
// Controller state machine of the character LCD text stream writer.
// Depends on clw_pkg for the command and status types.
module clw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  clw_pkg::clw_status_t status,
    output clw_pkg::clw_cmd_t    cmd
);
    import clw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHAR = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;
    localparam logic [1:0] ST_CMD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // A new request is taken only between runs.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd.latch_char = 1'b0;
        cmd.emit_char  = 1'b0;
        cmd.emit_pad   = 1'b0;
        cmd.emit_cmd   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!status.is_newline)
                    begin
                        cmd.latch_char = 1'b1;
                        if (status.col_lt_len)
                        begin
                            state_next = ST_CHAR;
                        end
                    end
                    else if (status.col_lt_limit)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (status.cmd_ok)
                    begin
                        state_next = ST_CMD;
                    end
                end
            end
            ST_CHAR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pad = 1'b1;
                    if (status.pad_last)
                    begin
                        state_next = status.cmd_ok ? ST_CMD : ST_IDLE;
                    end
                end
            end
            ST_CMD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_cmd = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/clw_dp.sv -----
// Datapath of the character LCD text stream writer: configuration, cursor,
// line addressing and the output register. Depends on clw_pkg.
module clw_dp #(
    parameter int DDRAM_LINE_LEN = clw_pkg::CLW_DDRAM_LINE_LEN
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [clw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [clw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [clw_pkg::CHAR_W-1:0]          text_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                reg_select,
    output logic [clw_pkg::CHAR_W-1:0]          bus_byte,
    output logic                                last_of_run,
    input  clw_pkg::clw_cmd_t                   cmd,
    output clw_pkg::clw_status_t                status
);
    import clw_pkg::*;

    localparam logic [COL_W-1:0] LINE_LEN = COL_W'(DDRAM_LINE_LEN);

    logic [LINES_W-1:0] line_count_reg;
    logic [COL_W-1:0]   column_count_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               out_valid_reg;
    logic               reg_select_reg;
    logic [CHAR_W-1:0]  bus_byte_reg;
    logic               last_of_run_reg;

    logic [LINES_W-1:0] eff_lines;
    logic [LINES_W-1:0] row_inc;
    logic [ROW_W-1:0]   wrap_row;
    logic [COL_W-1:0]   limit;
    logic [COL_W:0]     col_inc;
    logic               addr_ok;
    logic [CHAR_W-1:0]  line_addr;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg   <= LINE_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_COUNT:   line_count_reg   <= cfg_data[LINES_W-1:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Line count clamped to the range one to four.
    always_comb
    begin
        if (line_count_reg == '0)
        begin
            eff_lines = 3'd1;
        end
        else if (line_count_reg > 3'd4)
        begin
            eff_lines = 3'd4;
        end
        else
        begin
            eff_lines = line_count_reg;
        end
    end

    // Next line, wrapped by the clamped line count.
    assign row_inc = {1'b0, row_reg} + 3'd1;

    always_comb
    begin
        case (eff_lines)
            3'd1:    wrap_row = '0;
            3'd2:    wrap_row = {1'b0, row_inc[0]};
            3'd3:
            begin
                if (row_inc == 3'd3)
                begin
                    wrap_row = 2'd0;
                end
                else if (row_inc == 3'd4)
                begin
                    wrap_row = 2'd1;
                end
                else
                begin
                    wrap_row = row_inc[ROW_W-1:0];
                end
            end
            default: wrap_row = row_inc[ROW_W-1:0];
        endcase
    end

    // DDRAM start address of the next line; lines two and three exist only
    // on four-line displays of 12, 16 or 20 columns.
    always_comb
    begin
        addr_ok   = 1'b0;
        line_addr = ADDR_LINE0;
        case (wrap_row)
            2'd0:
            begin
                addr_ok = 1'b1;
            end
            2'd1:
            begin
                addr_ok   = (eff_lines >= 3'd2);
                line_addr = ADDR_LINE1;
            end
            default:
            begin
                if (eff_lines == 3'd4)
                begin
                    case (column_count_reg)
                        6'd12:
                        begin
                            addr_ok   = 1'b1;
                            line_addr = wrap_row[0] ? ADDR_L3_C12 : ADDR_L2_C12;
                        end
                        6'd16:
                        begin
                            addr_ok   = 1'b1;
                            line_addr = wrap_row[0] ? ADDR_L3_C16 : ADDR_L2_C16;
                        end
                        6'd20:
                        begin
                            addr_ok   = 1'b1;
                            line_addr = wrap_row[0] ? ADDR_L3_C20 : ADDR_L2_C20;
                        end
                        default:
                        begin
                            addr_ok = 1'b0;
                        end
                    endcase
                end
            end
        endcase
    end

    // Padding limit and cursor comparisons.
    assign limit   = (column_count_reg > LINE_LEN) ? LINE_LEN : column_count_reg;
    assign col_inc = {1'b0, col_reg} + 7'd1;

    assign status.is_newline   = (text_byte == CHAR_NEWLINE);
    assign status.col_lt_len   = (col_reg < LINE_LEN);
    assign status.col_lt_limit = (col_reg < limit);
    assign status.pad_last     = (col_inc >= {1'b0, limit});
    assign status.cmd_ok       = addr_ok;
    assign status.out_free     = !out_valid_reg || !out_stall;

    // Cursor update.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.emit_char || cmd.emit_pad)
        begin
            col_next = col_inc[COL_W-1:0];
        end
        else if (cmd.emit_cmd)
        begin
            col_next = '0;
            row_next = wrap_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Character held for the data write.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_char)
        begin
            char_reg <= text_byte;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_char || cmd.emit_pad || cmd.emit_cmd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_char)
        begin
            reg_select_reg  <= RS_DATA;
            bus_byte_reg    <= char_reg;
            last_of_run_reg <= 1'b1;
        end
        else if (cmd.emit_pad)
        begin
            reg_select_reg  <= RS_DATA;
            bus_byte_reg    <= CHAR_SPACE;
            last_of_run_reg <= status.pad_last && !addr_ok;
        end
        else if (cmd.emit_cmd)
        begin
            reg_select_reg  <= RS_COMMAND;
            bus_byte_reg    <= CMD_SET_DDRAM | line_addr;
            last_of_run_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reg_select  = reg_select_reg;
    assign bus_byte    = bus_byte_reg;
    assign last_of_run = last_of_run_reg;

endmodule

// ----- design/char_lcd_text_stream_writer_top.sv -----
// Top level of the character LCD text stream writer.
// Instantiates clw_ctrl and clw_dp; depends on clw_pkg.
//
// Usage: text bytes arrive on the input channel (in_valid, in_stall,
// text_byte); each request becomes zero or more LCD bus writes on the output
// channel (out_valid, out_stall, reg_select, bus_byte, last_of_run), with
// last_of_run marking the final write of a request. An ordinary byte gives
// one data write while the column is below the DDRAM line length; a newline
// gives space writes up to the visible width and then a DDRAM address
// command, where the next line can be addressed. Timing: a request is taken
// only while the controller is idle. A byte is accepted, then its writes are
// loaded one by one into the single output register, which takes one write
// per cycle while the receiver does not stall. Configuration (cfg_we,
// cfg_index, cfg_data) must be written between requests (the block does not
// enforce this) and takes effect at once.
// Reset clears the cursor to line 0, column 0, sets two lines of 16 columns
// and empties the output register. While the receiver stalls, the pending
// write holds steady and the controller waits, so no write is lost.
module char_lcd_text_stream_writer_top #(
    parameter int DDRAM_LINE_LEN = clw_pkg::CLW_DDRAM_LINE_LEN
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [clw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [clw_pkg::CHAR_W-1:0]      text_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            reg_select,
    output logic [clw_pkg::CHAR_W-1:0]      bus_byte,
    output logic                            last_of_run
);
    import clw_pkg::*;

    clw_cmd_t    cmd;
    clw_status_t status;

    // Controller.
    clw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    clw_dp #(
        .DDRAM_LINE_LEN (DDRAM_LINE_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reg_select  (reg_select),
        .bus_byte    (bus_byte),
        .last_of_run (last_of_run),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
